// ===== src/pfra_pkg.sv =====
// Shared types and constants of the port flow-rate accounting block.
package pfra_pkg;

   localparam int unsigned OWNERS   = 16;
   localparam int unsigned PORTS    = 8;
   localparam int unsigned SLOTS    = 8;
   localparam int unsigned OWNER_W  = 4;
   localparam int unsigned ENTRY_W  = 3;
   localparam int unsigned SLOT_W   = 3;
   localparam int unsigned ACT_W    = 5;
   localparam int unsigned ROWS     = OWNERS * PORTS;
   localparam int unsigned ADDR_W   = OWNER_W + ENTRY_W;
   localparam int unsigned SCAN_W   = ADDR_W + 1;
   localparam int unsigned CROW_W   = OWNER_W + SLOT_W;
   localparam int unsigned CROWS    = OWNERS * SLOTS;

   typedef enum logic [1:0] {
      ACT_PACKET    = 2'd0,
      ACT_WR_PORT   = 2'd1,
      ACT_WR_COUNT  = 2'd2,
      ACT_RD_CNT    = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK,
      ST_SCAN,
      ST_CNT_RD,
      ST_RESP
   } state_type;

   // One row of counters for one owner and one time slot.
   typedef struct packed {
      logic [47:0] tx_bytes;
      logic [31:0] tx_packets;
      logic [47:0] rx_bytes;
      logic [31:0] rx_packets;
   } cnt_row_type;

   typedef struct packed {
      logic capture;
      logic tick_step;
      logic scan_step;
      logic cnt_read;
      logic finish;
   } cmd_type;

   typedef struct packed {
      action_type action;
      logic       scan_done;
      logic       hit;
      logic       rsp_free;
   } status_type;

endpackage

// ===== src/pfra_ctrl.sv =====
// Controller state machine that sequences each transaction through the datapath.
module pfra_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  pfra_pkg::status_type status,
   output pfra_pkg::cmd_type    cmd
);

   pfra_pkg::state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pfra_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pfra_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = pfra_pkg::ST_TICK;
            end
         end
         pfra_pkg::ST_TICK: begin
            unique case (status.action)
               pfra_pkg::ACT_PACKET: state_in = pfra_pkg::ST_SCAN;
               pfra_pkg::ACT_RD_CNT: state_in = pfra_pkg::ST_CNT_RD;
               default:              state_in = pfra_pkg::ST_RESP;
            endcase
         end
         pfra_pkg::ST_SCAN: begin
            if (status.scan_done) begin
               state_in = status.hit ? pfra_pkg::ST_CNT_RD : pfra_pkg::ST_RESP;
            end
         end
         pfra_pkg::ST_CNT_RD: state_in = pfra_pkg::ST_RESP;
         pfra_pkg::ST_RESP: begin
            if (status.rsp_free) begin
               state_in = pfra_pkg::ST_IDLE;
            end
         end
         default: state_in = pfra_pkg::ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      req_tready    = 1'b0;
      cmd           = '0;
      unique case (state_ff)
         pfra_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         pfra_pkg::ST_TICK: begin
            cmd.tick_step = (status.action == pfra_pkg::ACT_PACKET);
         end
         pfra_pkg::ST_SCAN:   cmd.scan_step = 1'b1;
         pfra_pkg::ST_CNT_RD: cmd.cnt_read  = 1'b1;
         pfra_pkg::ST_RESP:   cmd.finish    = status.rsp_free;
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

// ===== src/pfra_datapath.sv =====
// Datapath: tables, counter memory, port scan and the response register.
module pfra_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [55:0]          req_tdata,
   input  logic [1:0]           req_tuser,
   input  logic                 csr_we,
   input  logic [4:0]           csr_wdata,
   input  pfra_pkg::cmd_type    cmd,
   output pfra_pkg::status_type status,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [167:0]         rsp_tdata
);

   // Captured transaction fields.
   pfra_pkg::action_type         action_ff;
   logic [7:0]                   tick_ff;
   logic [15:0]                  port_ff;
   logic                         outbound_ff;
   logic [15:0]                  length_ff;
   logic [pfra_pkg::OWNER_W-1:0] owner_ff;
   logic [pfra_pkg::ENTRY_W-1:0] entry_ff;
   logic [3:0]                   count_ff;
   logic [pfra_pkg::SLOT_W-1:0]  sel_ff;

   logic [pfra_pkg::ACT_W-1:0]   active_ff;
   logic [pfra_pkg::SLOT_W-1:0]  slot_ff;
   logic [7:0]                   last_tick_ff;
   logic [3:0]                   owner_cnt_ff [pfra_pkg::OWNERS];

   logic [15:0]                  port_mem [pfra_pkg::ROWS];
   logic [15:0]                  port_rd_ff;
   pfra_pkg::cnt_row_type        cnt_mem [pfra_pkg::CROWS];
   logic [pfra_pkg::CROWS-1:0]   cnt_vld_ff;
   pfra_pkg::cnt_row_type        cnt_rd_ff;
   logic                         cnt_rdv_ff;

   logic [pfra_pkg::SCAN_W-1:0]  scan_addr_ff;
   logic [pfra_pkg::ADDR_W-1:0]  cmp_addr_ff;
   logic                         cmp_vld_ff, cmp_vld_in;
   logic                         hit_ff;
   logic [pfra_pkg::OWNER_W-1:0] who_ff;

   logic                         rsp_valid_ff;
   logic [167:0]                 rsp_data_ff, rsp_data_in;

   logic [pfra_pkg::ACT_W-1:0]   act;
   logic                         tick_chg;
   logic [pfra_pkg::SLOT_W-1:0]  slot_next;
   logic                         scan_live;
   logic [pfra_pkg::ADDR_W-1:0]  scan_row;
   logic [pfra_pkg::OWNER_W-1:0] scan_owner;
   logic [pfra_pkg::CROW_W-1:0]  cnt_addr;
   pfra_pkg::cnt_row_type        cnt_base, cnt_upd;
   logic                         charge;
   logic [3:0]                   count_clip;

   // Active owner count is capped at the table size.
   assign act = (active_ff > pfra_pkg::ACT_W'(pfra_pkg::OWNERS))
              ? pfra_pkg::ACT_W'(pfra_pkg::OWNERS) : active_ff;
   assign tick_chg  = (tick_ff != last_tick_ff);
   assign slot_next = (slot_ff == pfra_pkg::SLOT_W'(pfra_pkg::SLOTS - 1))
                    ? '0 : slot_ff + 1'b1;

   // Scan address decode: an entry is live if its owner is active and it is
   // within that owner's port count.
   assign scan_row   = scan_addr_ff[pfra_pkg::ADDR_W-1:0];
   assign scan_owner = scan_row[pfra_pkg::ADDR_W-1:pfra_pkg::ENTRY_W];
   assign scan_live  = !scan_addr_ff[pfra_pkg::SCAN_W-1];
   assign cmp_vld_in = scan_live && !hit_ff
                     && ({1'b0, scan_owner} < act)
                     && ({1'b0, scan_row[pfra_pkg::ENTRY_W-1:0]} < owner_cnt_ff[scan_owner]);

   assign status.action    = action_ff;
   assign status.hit       = hit_ff;
   assign status.scan_done = hit_ff || (!scan_live && !cmp_vld_ff);
   assign status.rsp_free  = !rsp_valid_ff || rsp_tready;

   // Field capture, configuration and control registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff   <= pfra_pkg::action_type'(req_tuser);
         tick_ff     <= req_tdata[7:0];
         port_ff     <= req_tdata[23:8];
         outbound_ff <= req_tdata[24];
         length_ff   <= req_tdata[40:25];
         owner_ff    <= req_tdata[44:41];
         entry_ff    <= req_tdata[47:45];
         count_ff    <= req_tdata[51:48];
         sel_ff      <= req_tdata[54:52];
      end
      if (reset) begin
         active_ff    <= '0;
         slot_ff      <= '0;
         last_tick_ff <= '0;
      end else begin
         if (csr_we) begin
            active_ff <= csr_wdata;
         end
         if (cmd.tick_step) begin
            last_tick_ff <= tick_ff;
            if (tick_chg) begin
               slot_ff <= slot_next;
            end
         end
      end
   end

   // Count of valid port entries per owner.
   assign count_clip = (count_ff > 4'(pfra_pkg::PORTS)) ? 4'(pfra_pkg::PORTS) : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pfra_pkg::OWNERS; i++) begin
            owner_cnt_ff[i] <= '0;
         end
      end else if (cmd.finish && action_ff == pfra_pkg::ACT_WR_COUNT) begin
         owner_cnt_ff[owner_ff] <= count_clip;
      end
   end

   // Port table memory with registered read for the scan.
   always_ff @(posedge clock) begin
      if (cmd.finish && action_ff == pfra_pkg::ACT_WR_PORT) begin
         port_mem[{owner_ff, entry_ff}] <= port_ff;
      end
      port_rd_ff <= port_mem[scan_row];
   end

   // Scan sequencer: one entry issued and one compared per cycle.
   always_ff @(posedge clock) begin
      cmp_addr_ff <= scan_row;
      if (reset || cmd.tick_step) begin
         scan_addr_ff <= '0;
         cmp_vld_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         who_ff       <= '0;
      end else if (cmd.scan_step) begin
         cmp_vld_ff <= cmp_vld_in;
         if (scan_live) begin
            scan_addr_ff <= scan_addr_ff + 1'b1;
         end
         if (cmp_vld_ff && !hit_ff && port_rd_ff == port_ff && length_ff != 16'd0) begin
            hit_ff <= 1'b1;
            who_ff <= cmp_addr_ff[pfra_pkg::ADDR_W-1:pfra_pkg::ENTRY_W];
         end
      end
   end

   // Counter row selection and update.
   assign cnt_addr = (action_ff == pfra_pkg::ACT_PACKET) ? {who_ff, slot_ff}
                                                        : {owner_ff, sel_ff};
   assign charge   = (action_ff == pfra_pkg::ACT_PACKET) && hit_ff;
   assign cnt_base = cnt_rdv_ff ? cnt_rd_ff : '0;

   always_comb begin
      cnt_upd = cnt_base;
      if (charge) begin
         if (outbound_ff) begin
            cnt_upd.tx_packets = cnt_base.tx_packets + 32'd1;
            cnt_upd.tx_bytes   = cnt_base.tx_bytes + 48'(length_ff);
         end else begin
            cnt_upd.rx_packets = cnt_base.rx_packets + 32'd1;
            cnt_upd.rx_bytes   = cnt_base.rx_bytes + 48'(length_ff);
         end
      end
   end

   // Counter memory; rows not written since their last clear read as zero.
   always_ff @(posedge clock) begin
      if (cmd.cnt_read) begin
         cnt_rd_ff <= cnt_mem[cnt_addr];
      end
      if (cmd.finish && charge) begin
         cnt_mem[cnt_addr] <= cnt_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_vld_ff <= '0;
         cnt_rdv_ff <= 1'b0;
      end else begin
         if (cmd.cnt_read) begin
            cnt_rdv_ff <= cnt_vld_ff[cnt_addr];
         end
         if (cmd.tick_step && tick_chg) begin
            for (int i = 0; i < pfra_pkg::OWNERS; i++) begin
               if (pfra_pkg::ACT_W'(i) < act) begin
                  cnt_vld_ff[{pfra_pkg::OWNER_W'(i), slot_next}] <= 1'b0;
               end
            end
         end
         if (cmd.finish && charge) begin
            cnt_vld_ff[cnt_addr] <= 1'b1;
         end
      end
   end

   // Response assembly.
   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[7:5] = slot_ff;
      if (action_ff == pfra_pkg::ACT_PACKET) begin
         if (hit_ff) begin
            rsp_data_in[0]       = 1'b1;
            rsp_data_in[4:1]     = who_ff;
            rsp_data_in[167:8]   = cnt_upd;
         end
      end else begin
         rsp_data_in[4:1] = owner_ff;
         if (action_ff == pfra_pkg::ACT_RD_CNT) begin
            rsp_data_in[167:8] = cnt_base;
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_data_ff <= rsp_data_in;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== src/port_flow_rate_accounting.sv =====
// Top level of the port flow-rate accounting block.
// One transaction is handled at a time. A packet passes through capture, the
// tick check and slot clear, a scan of the port table entries (128, read one
// per cycle from the single port table memory), a drain of the read and
// compare pipeline, then one counter memory read and a final step that writes
// back and responds. A packet that matches nothing skips the counter read.
// Port and count writes skip the scan and the counter read; counter reads skip the scan.
// A new transaction is taken while the previous response waits in the output
// register.
module port_flow_rate_accounting (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: tick[7:0], port[23:8], outbound[24], length[40:25], owner[44:41],
   //        entry[47:45], count[51:48], slot_select[54:52], zero pad[55]
   input  logic [55:0]  req_tdata,
   // tuser: action[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: matched[0], owner_hit[4:1], current_slot[7:5], rx_packets[39:8],
   //        rx_bytes[87:40], tx_packets[119:88], tx_bytes[167:120]
   output logic [167:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [4:0]   csr_wdata
);

   pfra_pkg::cmd_type    cmd;
   pfra_pkg::status_type status;

   pfra_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pfra_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== src/pfra_checker.sv =====
// Port-level checker for the accounting block and its bind.
module pfra_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [167:0] rsp_tdata
);

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("response changed while stalled");

   // Only one transaction is in work at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   // No response right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_tvalid)
      else $error("response valid after reset");

   // A response only appears at the end of a transaction in work, while the
   // input side is still closed.
   a_no_rsp_without_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("response appeared without a transaction in work");

endmodule

bind port_flow_rate_accounting pfra_checker u_pfra_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench of the port flow-rate accounting block.
module tb_top;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  tick;
      logic [15:0] port;
      logic        outbound;
      logic [15:0] length;
      logic [3:0]  owner;
      logic [2:0]  entry;
      logic [3:0]  count;
      logic [2:0]  slot_select;
   } flow_req_type;

   // Packed from the highest bit down, so matched lands in bit 0.
   typedef struct packed {
      logic [47:0] tx_bytes;
      logic [31:0] tx_packets;
      logic [47:0] rx_bytes;
      logic [31:0] rx_packets;
      logic [2:0]  current_slot;
      logic [3:0]  owner_hit;
      logic        matched;
   } flow_rsp_type;

   localparam int CYCLE_LIMIT = 1500000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [55:0]  req_tdata = '0;
   logic [1:0]   req_tuser = pfra_pkg::ACT_PACKET;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [167:0] rsp_tdata;
   logic         csr_we = 1'b0;
   logic [4:0]   csr_wdata = '0;

   // Shadow copy of the block's tables.
   logic [15:0] port_shadow [pfra_pkg::ROWS];
   bit          port_known [pfra_pkg::ROWS];
   logic [3:0]  count_shadow [pfra_pkg::OWNERS];
   logic [31:0] rx_pkt_shadow [pfra_pkg::CROWS];
   logic [47:0] rx_byte_shadow [pfra_pkg::CROWS];
   logic [31:0] tx_pkt_shadow [pfra_pkg::CROWS];
   logic [47:0] tx_byte_shadow [pfra_pkg::CROWS];
   logic [2:0]  slot_shadow;
   logic [7:0]  tick_shadow;
   logic [4:0]  owners_shadow;

   flow_req_type pending_reqs [$];
   flow_rsp_type expected_rsps [$];
   int        mismatches = 0;
   int        cycles = 0;
   bit        stimulus_done = 1'b0;
   bit        quiet_send = 1'b0;
   bit        quiet_recv = 1'b0;
   int        hold_off = 0;
   bit        hold_armed = 1'b0;

   port_flow_rate_accounting i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // Computes the response of one transaction and updates the shadow tables.
   function automatic flow_rsp_type account_item(flow_req_type r);
      flow_rsp_type o;
      int act, n, row, who;
      bit hit;
      o = '0;
      act = (owners_shadow > pfra_pkg::OWNERS) ? pfra_pkg::OWNERS : owners_shadow;
      hit = 1'b0;
      who = 0;
      case (pfra_pkg::action_type'(r.action))
         pfra_pkg::ACT_PACKET: begin
            if (r.tick != tick_shadow) begin
               slot_shadow = slot_shadow + 3'd1;
               for (int i = 0; i < act; i++) begin
                  row = i * pfra_pkg::SLOTS + slot_shadow;
                  rx_pkt_shadow[row] = '0;
                  rx_byte_shadow[row] = '0;
                  tx_pkt_shadow[row] = '0;
                  tx_byte_shadow[row] = '0;
               end
            end
            tick_shadow = r.tick;
            if (r.length != 0) begin
               for (int i = 0; i < act && !hit; i++) begin
                  n = count_shadow[i];
                  for (int j = 0; j < n && !hit; j++) begin
                     if (port_shadow[i * pfra_pkg::PORTS + j] == r.port) begin
                        hit = 1'b1;
                        who = i;
                     end
                  end
               end
            end
            if (hit) begin
               row = who * pfra_pkg::SLOTS + slot_shadow;
               if (r.outbound) begin
                  tx_pkt_shadow[row] = tx_pkt_shadow[row] + 32'd1;
                  tx_byte_shadow[row] = tx_byte_shadow[row] + 48'(r.length);
               end else begin
                  rx_pkt_shadow[row] = rx_pkt_shadow[row] + 32'd1;
                  rx_byte_shadow[row] = rx_byte_shadow[row] + 48'(r.length);
               end
               o.matched = 1'b1;
               o.owner_hit = 4'(who);
               o.rx_packets = rx_pkt_shadow[row];
               o.rx_bytes = rx_byte_shadow[row];
               o.tx_packets = tx_pkt_shadow[row];
               o.tx_bytes = tx_byte_shadow[row];
            end
         end
         pfra_pkg::ACT_WR_PORT: begin
            port_shadow[r.owner * pfra_pkg::PORTS + r.entry] = r.port;
            port_known[r.owner * pfra_pkg::PORTS + r.entry] = 1'b1;
            o.owner_hit = r.owner;
         end
         pfra_pkg::ACT_WR_COUNT: begin
            count_shadow[r.owner] = (r.count > pfra_pkg::PORTS)
                                    ? 4'(pfra_pkg::PORTS) : r.count;
            o.owner_hit = r.owner;
         end
         default: begin
            row = r.owner * pfra_pkg::SLOTS + r.slot_select;
            o.owner_hit = r.owner;
            o.rx_packets = rx_pkt_shadow[row];
            o.rx_bytes = rx_byte_shadow[row];
            o.tx_packets = tx_pkt_shadow[row];
            o.tx_bytes = tx_byte_shadow[row];
         end
      endcase
      o.current_slot = slot_shadow;
      return o;
   endfunction

   function automatic flow_req_type make_req(logic [1:0] a, logic [7:0] t, logic [15:0] p,
                                             logic ob, logic [15:0] len, logic [3:0] ow,
                                             logic [2:0] en, logic [3:0] cn, logic [2:0] ss);
      flow_req_type r;
      r.action = a; r.tick = t; r.port = p; r.outbound = ob; r.length = len;
      r.owner = ow; r.entry = en; r.count = cn; r.slot_select = ss;
      return r;
   endfunction

   // Random item; a port count only covers entries that have been written.
   function automatic flow_req_type random_req(logic [7:0] t);
      flow_req_type r;
      int k, roll;
      r = make_req(pfra_pkg::ACT_PACKET, t, 16'($urandom), 1'($urandom),
                   16'($urandom_range(1, 1500)), 4'($urandom), 3'($urandom),
                   4'($urandom_range(0, 8)), 3'($urandom));
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) r.length = 16'($urandom);
      if (roll < 8) begin
         r.action = pfra_pkg::ACT_WR_PORT;
         r.port = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 15));
      end else if (roll < 14) begin
         r.action = pfra_pkg::ACT_WR_COUNT;
         k = 0;
         while (k < pfra_pkg::PORTS && port_known[r.owner * pfra_pkg::PORTS + k]) k++;
         r.count = (k == pfra_pkg::PORTS && $urandom_range(0, 3) == 0)
                   ? 4'($urandom_range(8, 15)) : 4'($urandom_range(0, k));
      end else if (roll < 30) begin
         r.action = pfra_pkg::ACT_RD_CNT;
      end else if ($urandom_range(0, 4) != 0) begin
         r.port = 16'($urandom_range(0, 15));
      end
      return r;
   endfunction

   // Queues an item and predicts its response at once, in order.
   task automatic push_req(flow_req_type r);
      pending_reqs.push_back(r);
      expected_rsps.push_back(account_item(r));
   endtask

   // Waits for every response, plus the busy tail, then writes the register.
   task automatic write_owners(logic [4:0] v);
      while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      owners_shadow = v;
   endtask

   // Driver: presents queued items, idling at random.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) void'(pending_reqs.pop_front());
         if ((!req_tvalid || req_tready) || !req_tvalid) begin
            if ((req_tvalid && !req_tready)) begin
            end else if (pending_reqs.size() != 0 && (req_tvalid && req_tready
                         ? pending_reqs.size() != 0 : 1'b1)
                         && (quiet_send || $urandom_range(0, 99) >= 34)) begin
               req_tvalid <= 1'b1;
               req_tuser <= pending_reqs[0].action;
               req_tdata <= {1'b0, pending_reqs[0].slot_select, pending_reqs[0].count,
                             pending_reqs[0].entry, pending_reqs[0].owner,
                             pending_reqs[0].length, pending_reqs[0].outbound,
                             pending_reqs[0].port, pending_reqs[0].tick};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver readiness, with one long hold-off while items keep coming.
   always @(posedge clock) begin
      if (!reset) begin
         if (hold_armed) begin
            hold_armed <= 1'b0;
            hold_off <= 400;
            rsp_tready <= 1'b0;
         end else if (hold_off != 0) begin
            hold_off <= hold_off - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= quiet_recv || $urandom_range(0, 99) >= 34;
         end
      end
   end

   // Monitor: compares each response with the oldest prediction.
   always @(posedge clock) begin
      flow_rsp_type got, want;
      cycles <= cycles + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", rsp_tdata);
         end else begin
            want = expected_rsps.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p, got %p", want, got);
            end
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      logic [7:0] t;
      int sent;
      for (int i = 0; i < pfra_pkg::ROWS; i++) port_known[i] = 1'b0;
      for (int i = 0; i < pfra_pkg::OWNERS; i++) count_shadow[i] = '0;
      for (int i = 0; i < pfra_pkg::CROWS; i++) begin
         rx_pkt_shadow[i] = '0; rx_byte_shadow[i] = '0;
         tx_pkt_shadow[i] = '0; tx_byte_shadow[i] = '0;
      end
      slot_shadow = '0; tick_shadow = '0; owners_shadow = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: zero owners, table setup, extremes and out-of-range counts.
      push_req(make_req(pfra_pkg::ACT_PACKET, 8'd0, 16'd0, 1'b0, 16'd0, 4'd0, 3'd0,
                        4'd0, 3'd0));
      for (int e = 0; e < pfra_pkg::PORTS; e++)
         push_req(make_req(pfra_pkg::ACT_WR_PORT, 8'hFF, 16'(e == 7 ? 16'hFFFF : e), 1'b1,
                           16'hFFFF, 4'd15, 3'(e), 4'hF, 3'd7));
      push_req(make_req(pfra_pkg::ACT_WR_PORT, 8'd0, 16'h0, 1'b0, 16'd0, 4'd0, 3'd0,
                        4'd0, 3'd0));
      push_req(make_req(pfra_pkg::ACT_WR_COUNT, 8'd0, 16'd0, 1'b0, 16'd0, 4'd15, 3'd0,
                        4'd15, 3'd0));
      push_req(make_req(pfra_pkg::ACT_WR_COUNT, 8'd0, 16'd0, 1'b0, 16'd0, 4'd0, 3'd0,
                        4'd1, 3'd0));
      write_owners(5'd16);
      push_req(make_req(pfra_pkg::ACT_PACKET, 8'd1, 16'hFFFF, 1'b1, 16'hFFFF, 4'd0, 3'd0,
                        4'd0, 3'd0));
      push_req(make_req(pfra_pkg::ACT_PACKET, 8'd1, 16'hFFFF, 1'b0, 16'hFFFF, 4'd0, 3'd0,
                        4'd0, 3'd0));
      push_req(make_req(pfra_pkg::ACT_PACKET, 8'd1, 16'h0000, 1'b0, 16'd0, 4'd0, 3'd0,
                        4'd0, 3'd0));
      push_req(make_req(pfra_pkg::ACT_PACKET, 8'd1, 16'h0000, 1'b0, 16'd1, 4'd0, 3'd0,
                        4'd0, 3'd0));
      push_req(make_req(pfra_pkg::ACT_PACKET, 8'd2, 16'h1234, 1'b0, 16'd9, 4'd0, 3'd0,
                        4'd0, 3'd0));
      push_req(make_req(pfra_pkg::ACT_RD_CNT, 8'd0, 16'd0, 1'b0, 16'd0, 4'd15, 3'd0,
                        4'd0, 3'd1));
      push_req(make_req(pfra_pkg::ACT_RD_CNT, 8'hFF, 16'hFFFF, 1'b1, 16'hFFFF, 4'd0, 3'd7,
                        4'd8, 3'd7));
      write_owners(5'd31);
      push_req(make_req(pfra_pkg::ACT_PACKET, 8'd3, 16'd3, 1'b1, 16'd5, 4'd0, 3'd0,
                        4'd0, 3'd0));

      // Random phases across several owner counts; long stretch without idling.
      t = 8'd3;
      sent = 0;
      for (int ph = 0; ph < 6; ph++) begin
         write_owners(ph == 0 ? 5'd0 : ph == 1 ? 5'd1 : ph == 5 ? 5'd16
                      : 5'($urandom_range(2, 31)));
         quiet_send = (ph == 3);
         quiet_recv = (ph == 3);
         if (ph == 2) hold_armed = 1'b1;
         for (int k = 0; k < 190; k++) begin
            if ($urandom_range(0, 5) == 0)
               t = $urandom_range(0, 3) == 0 ? 8'($urandom) : t + 8'd1;
            push_req(random_req(t));
            sent++;
            while (pending_reqs.size() > 4) @(posedge clock);
         end
      end
      quiet_send = 1'b0;
      quiet_recv = 1'b0;
      while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
